// ===== sv/hgt_pkg.sv =====
// Shared types and constants for the height grid triangulator.
// Used by hgt_cell, the top level and the testbench; depends on nothing else.
package hgt_pkg;

  localparam int IdxW    = 20;
  localparam int HeightW = 32;
  localparam int RegW    = 11;
  localparam int DefaultSize = 20;

  // Output queue depth in triangles and the room kept free for one vertex.
  localparam int OutDepth = 4;
  localparam int MaxFacets = 2;

  // One grid vertex: compacted index with an invalid flag, plus elevation.
  typedef struct packed {
    logic                      bad;
    logic [IdxW-1:0]           idx;
    logic signed [HeightW-1:0] height;
  } vert_t;

  // The four corners of a cell as they arrive at the triangulation stage.
  typedef struct packed {
    logic  swap;
    vert_t cur;
    vert_t left;
    vert_t low_l;
    vert_t low_r;
  } corners_t;

  typedef struct packed {
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] second;
    logic [IdxW-1:0] third;
    logic            run_end;
  } facet_t;

  typedef struct packed {
    logic [1:0] count;
    facet_t     facet0;
    facet_t     facet1;
  } cell_out_t;

endpackage

// ===== sv/hgt_cell.sv =====
// Cell triangulation: picks the valid corners and the shorter diagonal.
// Depends on hgt_pkg.
module hgt_cell (
  input  logic              en,
  input  hgt_pkg::corners_t crn,
  output hgt_pkg::cell_out_t res
);

  hgt_pkg::vert_t c00, c01, c10, c11;
  logic        ok00, ok01, ok10, ok11;
  logic [2:0]  n_ok;
  logic signed [hgt_pkg::HeightW:0] d0, d1;
  logic [hgt_pkg::HeightW:0] a0, a1;
  logic        main_diag;

  always_comb begin
    if (!crn.swap) begin
      c00 = crn.low_l;
      c01 = crn.left;
      c10 = crn.low_r;
      c11 = crn.cur;
    end else begin
      c00 = crn.left;
      c01 = crn.low_l;
      c10 = crn.cur;
      c11 = crn.low_r;
    end
    ok00 = ~c00.bad;
    ok01 = ~c01.bad;
    ok10 = ~c10.bad;
    ok11 = ~c11.bad;
    n_ok = 3'({2'b0, ok00}) + 3'({2'b0, ok01}) + 3'({2'b0, ok10}) + 3'({2'b0, ok11});

    d0 = {c00.height[hgt_pkg::HeightW-1], c00.height} -
         {c11.height[hgt_pkg::HeightW-1], c11.height};
    d1 = {c01.height[hgt_pkg::HeightW-1], c01.height} -
         {c10.height[hgt_pkg::HeightW-1], c10.height};
    a0 = d0[hgt_pkg::HeightW] ? (hgt_pkg::HeightW+1)'(-d0) : (hgt_pkg::HeightW+1)'(d0);
    a1 = d1[hgt_pkg::HeightW] ? (hgt_pkg::HeightW+1)'(-d1) : (hgt_pkg::HeightW+1)'(d1);
    main_diag = a0 < a1;

    res = '0;
    if (en && n_ok == 3'd4) begin
      res.count = 2'd2;
      if (main_diag) begin
        res.facet0 = '{first: c01.idx, second: c00.idx, third: c11.idx, run_end: 1'b0};
        res.facet1 = '{first: c00.idx, second: c10.idx, third: c11.idx, run_end: 1'b1};
      end else begin
        res.facet0 = '{first: c01.idx, second: c00.idx, third: c10.idx, run_end: 1'b0};
        res.facet1 = '{first: c01.idx, second: c10.idx, third: c11.idx, run_end: 1'b1};
      end
    end else if (en && n_ok == 3'd3) begin
      res.count = 2'd1;
      // Keep corner order 00, 01, 11, 10 and skip the missing one.
      priority if (!ok00) begin
        res.facet0 = '{first: c01.idx, second: c11.idx, third: c10.idx, run_end: 1'b1};
      end else if (!ok01) begin
        res.facet0 = '{first: c00.idx, second: c11.idx, third: c10.idx, run_end: 1'b1};
      end else if (!ok11) begin
        res.facet0 = '{first: c00.idx, second: c01.idx, third: c10.idx, run_end: 1'b1};
      end else begin
        res.facet0 = '{first: c00.idx, second: c01.idx, third: c11.idx, run_end: 1'b1};
      end
    end
  end

endmodule

// ===== sv/height_grid_triangulator_top.sv =====
// Top level of the height grid triangulator: counters, line buffer memory,
// triangulation stage and output queue. Depends on hgt_pkg and hgt_cell.
//
//   channel   dir  handshake              payload
//   config    in   psel/penable/pready    paddr, pwdata, pwrite -> prdata
//   vertex    in   in_valid/in_ready      vertex_valid, elevation
//   triangle  out  out_valid/out_ready    corner_first/second/third, run_end
//
// The line buffer read for a vertex returns the next cycle, where the cell is
// triangulated and up to two triangles enter a 4-deep queue. Triangles leave
// one per cycle while out_ready is high, and in_ready reserves two queue slots
// for the cell in flight, so a new vertex can be taken while the previous cell
// is still in flight. Reset (rst, synchronous) empties the queue and restarts
// the frame; the line buffer is not cleared since every entry is written in a
// frame's first row before it is read. A stalled output holds the queue and
// closes in_ready once the queue plus the cell in flight leave fewer than two
// free slots.
module height_grid_triangulator_top #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // vertex stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        vertex_valid,
  input  logic signed [hgt_pkg::HeightW-1:0] elevation,
  // triangle stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [hgt_pkg::IdxW-1:0] corner_first,
  output logic [hgt_pkg::IdxW-1:0] corner_second,
  output logic [hgt_pkg::IdxW-1:0] corner_third,
  output logic        run_end
);

  localparam int ColW = $clog2(MAX_COLUMNS);
  localparam int RowW = $clog2(MAX_ROWS);
  localparam int ColSzW = ($clog2(MAX_COLUMNS + 1) > hgt_pkg::RegW) ?
                          $clog2(MAX_COLUMNS + 1) : hgt_pkg::RegW;
  localparam int RowSzW = ($clog2(MAX_ROWS + 1) > hgt_pkg::RegW) ?
                          $clog2(MAX_ROWS + 1) : hgt_pkg::RegW;
  localparam int ColLastRst = (hgt_pkg::DefaultSize > MAX_COLUMNS) ?
                              MAX_COLUMNS - 1 : hgt_pkg::DefaultSize - 1;
  localparam int RowLastRst = (hgt_pkg::DefaultSize > MAX_ROWS) ?
                              MAX_ROWS - 1 : hgt_pkg::DefaultSize - 1;
  localparam int PtrW = $clog2(hgt_pkg::OutDepth);
  localparam int CntW = $clog2(hgt_pkg::OutDepth + 1);

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] RegGridColumns = 2'd0;
  localparam logic [1:0] RegGridRows    = 2'd1;
  localparam logic [1:0] RegSwap        = 2'd2;

  // ---------------------------------------------------------------- config
  logic [hgt_pkg::RegW-1:0] grid_columns, grid_rows;
  logic                     swap_orientation;
  logic [ColW-1:0]          col_last, col_last_wr;
  logic [RowW-1:0]          row_last, row_last_wr;
  logic [ColSzW-1:0]        wr_cols;
  logic [RowSzW-1:0]        wr_rows;
  logic                     cfg_wr, restart;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign restart = cfg_wr & (paddr[3:2] == RegGridColumns || paddr[3:2] == RegGridRows);

  // Saturate the written size into the supported range and keep size - 1.
  always_comb begin
    wr_cols = ColSzW'(pwdata[hgt_pkg::RegW-1:0]);
    wr_rows = RowSzW'(pwdata[hgt_pkg::RegW-1:0]);
    if (wr_cols < ColSzW'(2)) begin
      col_last_wr = ColW'(1);
    end else if (wr_cols > ColSzW'(MAX_COLUMNS)) begin
      col_last_wr = ColW'(MAX_COLUMNS - 1);
    end else begin
      col_last_wr = ColW'(wr_cols - ColSzW'(1));
    end
    if (wr_rows < RowSzW'(2)) begin
      row_last_wr = RowW'(1);
    end else if (wr_rows > RowSzW'(MAX_ROWS)) begin
      row_last_wr = RowW'(MAX_ROWS - 1);
    end else begin
      row_last_wr = RowW'(wr_rows - RowSzW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns     <= hgt_pkg::RegW'(hgt_pkg::DefaultSize);
      grid_rows        <= hgt_pkg::RegW'(hgt_pkg::DefaultSize);
      swap_orientation <= 1'b0;
      col_last         <= ColW'(ColLastRst);
      row_last         <= RowW'(RowLastRst);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegGridColumns: begin
          grid_columns <= pwdata[hgt_pkg::RegW-1:0];
          col_last     <= col_last_wr;
        end
        RegGridRows: begin
          grid_rows <= pwdata[hgt_pkg::RegW-1:0];
          row_last  <= row_last_wr;
        end
        RegSwap: begin
          swap_orientation <= pwdata[0];
        end
        default: begin
          // unmapped register: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegGridColumns: prdata = 32'(grid_columns);
      RegGridRows:    prdata = 32'(grid_rows);
      RegSwap:        prdata = 32'(swap_orientation);
      default:        prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------- vertex intake
  logic                    in_xfer;
  logic [ColW-1:0]         col_cnt;
  logic [RowW-1:0]         row_cnt;
  logic [hgt_pkg::IdxW-1:0] next_idx, next_idx_next;
  hgt_pkg::vert_t          left, cur;
  logic                    col_end, row_end;

  assign in_xfer = in_valid & in_ready;
  assign col_end = (col_cnt == col_last);
  assign row_end = (row_cnt == row_last);

  always_comb begin
    cur.bad    = ~vertex_valid;
    cur.idx    = vertex_valid ? next_idx : '0;
    cur.height = elevation;
    next_idx_next = vertex_valid ? next_idx + hgt_pkg::IdxW'(1) : next_idx;
    // A frame ends at the last column of the last row: restart numbering.
    if (col_end && row_end) begin
      next_idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      next_idx <= '0;
      left     <= '{bad: 1'b1, idx: '0, height: '0};
    end else if (in_xfer) begin
      next_idx <= next_idx_next;
      if (col_end) begin
        col_cnt <= '0;
        row_cnt <= row_end ? '0 : row_cnt + RowW'(1);
        left    <= '{bad: 1'b1, idx: '0, height: '0};
      end else begin
        col_cnt <= col_cnt + ColW'(1);
        left    <= cur;
      end
    end
  end

  // -------------------------------------------------------- line buffer
  // Entry c holds the previous row's vertex at column c until this row's
  // vertex at column c overwrites it; read and write share the cycle, and the
  // read returns the old content. Column c-1 of the previous row is the read
  // result of the previous vertex, kept in prev_rd.
  hgt_pkg::vert_t line_mem [MAX_COLUMNS];
  hgt_pkg::vert_t rd_data, prev_rd;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      line_mem[col_cnt] <= cur;
      rd_data           <= line_mem[col_cnt];
    end
  end

  // ------------------------------------------------ triangulation stage
  logic               s1_valid, s1_en, s1_swap;
  hgt_pkg::vert_t     s1_cur, s1_left;
  hgt_pkg::corners_t  crn;
  hgt_pkg::cell_out_t cell_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_en   <= (col_cnt != '0) && (row_cnt != '0);
      s1_swap <= swap_orientation;
      s1_cur  <= cur;
      s1_left <= left;
    end
    if (s1_valid) begin
      prev_rd <= rd_data;
    end
  end

  assign crn = '{swap: s1_swap, cur: s1_cur, left: s1_left, low_l: prev_rd, low_r: rd_data};

  hgt_cell u_cell (
    .en  (s1_valid & s1_en),
    .crn (crn),
    .res (cell_res)
  );

  // -------------------------------------------------------- output queue
  hgt_pkg::facet_t  out_q [hgt_pkg::OutDepth];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  q_cnt, push_n, s1_need;
  logic             out_xfer;

  assign out_valid = (q_cnt != '0);
  assign out_xfer  = out_valid & out_ready;
  assign push_n    = s1_valid ? CntW'(cell_res.count) : '0;
  assign s1_need   = s1_valid ? CntW'(hgt_pkg::MaxFacets) : '0;
  // Take a vertex only if the queue can absorb the worst case of the cell in
  // flight plus this one.
  assign in_ready  = (q_cnt + s1_need) <= CntW'(hgt_pkg::OutDepth - hgt_pkg::MaxFacets);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      q_cnt  <= q_cnt + push_n - CntW'(out_xfer);
      wr_ptr <= wr_ptr + PtrW'(push_n);
      if (out_xfer) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      out_q[wr_ptr] <= cell_res.facet0;
    end
    if (push_n == CntW'(hgt_pkg::MaxFacets)) begin
      out_q[wr_ptr + PtrW'(1)] <= cell_res.facet1;
    end
  end

  assign corner_first  = out_q[rd_ptr].first;
  assign corner_second = out_q[rd_ptr].second;
  assign corner_third  = out_q[rd_ptr].third;
  assign run_end       = out_q[rd_ptr].run_end;

endmodule

// ===== verif/height_grid_triangulator_top_tb.sv =====
// Self-checking testbench for height_grid_triangulator_top: a directed table,
// then random vertex frames; triangles checked against typed-in ones or a predictor.
// Depends on hgt_pkg and the height_grid_triangulator_top RTL.
module height_grid_triangulator_top_tb;

  localparam int MAX_COLS      = 1024;
  localparam int MAX_GRID_ROWS = 1024;
  localparam int RANDOM_ITEMS  = 900;
  // Idle cycles after the last triangle so a vertex that gives none has cleared
  // the read and triangulation stages before any register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;

  // Register byte addresses; the spare slot decodes to no register.
  localparam logic [3:0] ADDR_COLUMNS = 4'h0;
  localparam logic [3:0] ADDR_ROWS    = 4'h4;
  localparam logic [3:0] ADDR_SWAP    = 4'h8;
  localparam logic [3:0] ADDR_SPARE   = 4'hC;

  localparam hgt_pkg::vert_t NO_VERTEX = {1'b1, {hgt_pkg::IdxW{1'b0}},
                                          {hgt_pkg::HeightW{1'b0}}};

  typedef enum logic {ROW_WRITE, ROW_VERTEX} row_kind_t;

  // One directed step: a register write, or a vertex whose triangles are either
  // typed in here (known = 1) or taken from the predictor.
  typedef struct packed {
    row_kind_t       kind;
    logic [3:0]      addr;
    logic [31:0]     data;     // register value, or elevation of a vertex
    logic            vv;
    logic            known;
    logic [1:0]      n_known;
    hgt_pkg::facet_t t0;
    hgt_pkg::facet_t t1;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TRICKLE, RX_BEAT} rx_mode_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [3:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     vertex_valid = 1'b0;
  logic signed [31:0]       elevation = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [hgt_pkg::IdxW-1:0] corner_first;
  logic [hgt_pkg::IdxW-1:0] corner_second;
  logic [hgt_pkg::IdxW-1:0] corner_third;
  logic                     run_end;

  height_grid_triangulator_top #(
    .MAX_COLUMNS(MAX_COLS),
    .MAX_ROWS   (MAX_GRID_ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vertex_valid (vertex_valid),
    .elevation    (elevation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .corner_first (corner_first),
    .corner_second(corner_second),
    .corner_third (corner_third),
    .run_end      (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register copies, line buffer, left vertex and counters.
  // ---------------------------------------------------------------------------
  logic [10:0]              reg_columns;
  logic [10:0]              reg_rows;
  logic                     reg_swap;
  hgt_pkg::vert_t           line_buf [MAX_COLS];
  hgt_pkg::vert_t           left_vert;
  int                       col_pos;
  int                       row_pos;
  logic [hgt_pkg::IdxW-1:0] next_index;

  // Triangles still owed by the block, oldest first.
  hgt_pkg::facet_t pending_facets [$];
  int              error_count = 0;

  function automatic void owe_facet(input hgt_pkg::facet_t f);
    pending_facets = {pending_facets, f};
  endfunction

  function automatic int clamp_size(input logic [10:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic void restart_frame();
    left_vert  = NO_VERTEX;
    col_pos    = 0;
    row_pos    = 0;
    next_index = '0;
  endfunction

  function automatic longint abs_gap(input logic signed [31:0] a, input logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic hgt_pkg::facet_t make_facet(input logic [hgt_pkg::IdxW-1:0] a,
                                                 input logic [hgt_pkg::IdxW-1:0] b,
                                                 input logic [hgt_pkg::IdxW-1:0] c,
                                                 input logic last);
    hgt_pkg::facet_t f;
    f.first   = a;
    f.second  = b;
    f.third   = c;
    f.run_end = last;
    return f;
  endfunction

  // Triangle with corner indexes typed in as small numbers.
  function automatic hgt_pkg::facet_t typed_facet(input int a, input int b, input int c,
                                                  input logic last);
    return make_facet(hgt_pkg::IdxW'(a), hgt_pkg::IdxW'(b), hgt_pkg::IdxW'(c), last);
  endfunction

  // Number one vertex, triangulate the cell it closes and advance the grid.
  // Returns how many triangles the vertex gives (0..2) in f0, f1.
  function automatic int triangulate_vertex(input logic vv, input logic signed [31:0] h,
                                            output hgt_pkg::facet_t f0,
                                            output hgt_pkg::facet_t f1);
    int                       cols, rows, c, r, m, k;
    hgt_pkg::vert_t           cur, v00, v01, v10, v11;
    hgt_pkg::vert_t           corner [4];
    logic [hgt_pkg::IdxW-1:0] pick [3];
    int                       n;
    n  = 0;
    f0 = '0;
    f1 = '0;
    cols = clamp_size(reg_columns, MAX_COLS);
    rows = clamp_size(reg_rows, MAX_GRID_ROWS);
    if (col_pos >= cols || row_pos >= rows) restart_frame();
    c = col_pos;
    r = row_pos;
    cur.bad    = !vv;
    cur.idx    = vv ? next_index : '0;
    cur.height = h;
    if (vv) next_index = next_index + 1'b1;

    if (c > 0 && r > 0) begin
      // Without swap the lower row comes from the line buffer; swap exchanges rows.
      if (!reg_swap) begin
        v00 = line_buf[c-1]; v01 = left_vert; v10 = line_buf[c]; v11 = cur;
      end else begin
        v00 = left_vert; v01 = line_buf[c-1]; v10 = cur; v11 = line_buf[c];
      end
      // Gather valid corners in the order a lone triangle uses.
      corner[0] = v00; corner[1] = v01; corner[2] = v11; corner[3] = v10;
      m = 0;
      for (k = 0; k < 4; k++) begin
        if (!corner[k].bad) begin
          if (m < 3) pick[m] = corner[k].idx;
          m++;
        end
      end
      if (m == 4) begin
        // Split along the diagonal with the smaller elevation step; ties go cross.
        if (abs_gap(v00.height, v11.height) < abs_gap(v01.height, v10.height)) begin
          f0 = make_facet(v01.idx, v00.idx, v11.idx, 1'b0);
          f1 = make_facet(v00.idx, v10.idx, v11.idx, 1'b1);
        end else begin
          f0 = make_facet(v01.idx, v00.idx, v10.idx, 1'b0);
          f1 = make_facet(v01.idx, v10.idx, v11.idx, 1'b1);
        end
        n = 2;
      end else if (m == 3) begin
        f0 = make_facet(pick[0], pick[1], pick[2], 1'b1);
        n = 1;
      end
    end

    // The finished left vertex moves into the line buffer; the row's last
    // vertex goes in directly since no vertex follows it in this row.
    if (c > 0) line_buf[c-1] = left_vert;
    if (c + 1 == cols) line_buf[c] = cur;
    left_vert = cur;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) begin
        r = 0;
        next_index = '0;
      end
      left_vert = NO_VERTEX;
    end
    col_pos = c;
    row_pos = r;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All run from the main initial block, right after a rising edge.
  // ---------------------------------------------------------------------------

  // Drop valid and hold until every owed triangle is out and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_facets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle held until pready, then idle with psel low so
  // back-to-back writes never lower and raise psel in the same step.
  task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      ADDR_COLUMNS: begin
        reg_columns = data[10:0];
        restart_frame();
      end
      ADDR_ROWS: begin
        reg_rows = data[10:0];
        restart_frame();
      end
      ADDR_SWAP: reg_swap = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Present one vertex and hold it until the transfer; then log what it owes.
  task automatic send_vertex(input logic vv, input logic [31:0] h, input logic known,
                             input int n_known, input hgt_pkg::facet_t t0,
                             input hgt_pkg::facet_t t1);
    hgt_pkg::facet_t p0, p1;
    int              n;
    vertex_valid <= vv;
    elevation    <= h;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    n = triangulate_vertex(vv, h, p0, p1);
    if (known) begin
      n  = n_known;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) owe_facet(p0);
    if (n > 1) owe_facet(p1);
  endtask

  // Random vertices in bursts with random gaps; now and then hold off until
  // the triangle stream has fully drained.
  task automatic run_vertices(input int count, input int valid_pct);
    int          burst, gap, k;
    logic [31:0] h;
    burst = 0;
    for (k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: gap = 0;
          8: gap = $urandom_range(8, 30);
          9: gap = -1;
          default: gap = $urandom_range(1, 4);
        endcase
        if (gap != 0) begin
          in_valid <= 1'b0;
          if (gap < 0) begin
            while (pending_facets.size() != 0) @(posedge clk);
          end else begin
            repeat (gap) @(posedge clk);
          end
        end
      end
      burst--;
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: h = 32'h7FFF_FFFF;
            1: h = 32'h8000_0000;
            2: h = 32'h0000_0000;
            default: h = 32'hFFFF_FFFF;
          endcase
        end
        1, 2, 3: h = $urandom();
        // Whole units from a tiny set: many equal diagonals.
        4, 5, 6, 7: h = $urandom_range(0, 3) << 16;
        default: h = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      endcase
      send_vertex($urandom_range(0, 99) < valid_pct, h, 1'b0, 0, '0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: switch at random between stall patterns.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:    out_ready <= 1'b1;
      RX_COIN:    out_ready <= $urandom_range(0, 1);
      RX_TRICKLE: out_ready <= ($urandom_range(0, 7) == 0);
      default:    out_ready <= (rx_tick % 5 != 0);
    endcase
  end

  // Compare every triangle transfer with the oldest owed triangle.
  always @(posedge clk) begin
    hgt_pkg::facet_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_facets.size() == 0) begin
        $error("triangle with nothing owed: %0d %0d %0d run_end %0d",
               corner_first, corner_second, corner_third, run_end);
        error_count++;
      end else begin
        want = pending_facets.pop_front();
        if (corner_first !== want.first) begin
          $error("corner_first expected %0d actual %0d", want.first, corner_first);
          error_count++;
        end
        if (corner_second !== want.second) begin
          $error("corner_second expected %0d actual %0d", want.second, corner_second);
          error_count++;
        end
        if (corner_third !== want.third) begin
          $error("corner_third expected %0d actual %0d", want.third, corner_third);
          error_count++;
        end
        if (run_end !== want.run_end) begin
          $error("run_end expected %0d actual %0d", want.run_end, run_end);
          error_count++;
        end
      end
    end
  end

  // Watchdog on a hung handshake.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  stim_row_t directed [$];

  function automatic void add_row(input stim_row_t s);
    directed = {directed, s};
  endfunction

  function automatic stim_row_t write_row(input logic [3:0] addr, input logic [31:0] data);
    stim_row_t s;
    s      = '0;
    s.kind = ROW_WRITE;
    s.addr = addr;
    s.data = data;
    return s;
  endfunction

  function automatic stim_row_t vertex_row(input logic vv, input logic [31:0] h);
    stim_row_t s;
    s      = '0;
    s.kind = ROW_VERTEX;
    s.vv   = vv;
    s.data = h;
    return s;
  endfunction

  function automatic stim_row_t known_row(input logic vv, input logic [31:0] h, input int n,
                                          input hgt_pkg::facet_t t0,
                                          input hgt_pkg::facet_t t1);
    stim_row_t s;
    s         = vertex_row(vv, h);
    s.known   = 1'b1;
    s.n_known = 2'(n);
    s.t0      = t0;
    s.t1      = t1;
    return s;
  endfunction

  initial begin
    int          phase_no, random_sent, items, pct;
    logic [31:0] cols_word, rows_word;

    reg_columns = 11'(hgt_pkg::DefaultSize);
    reg_rows    = 11'(hgt_pkg::DefaultSize);
    reg_swap    = 1'b0;
    restart_frame();

    // 2x2 grid, all flat: both diagonals tie, so the cross split is taken.
    add_row(write_row(ADDR_COLUMNS, 32'd2));
    add_row(write_row(ADDR_ROWS, 32'd2));
    add_row(vertex_row(1'b1, 32'h0));
    add_row(vertex_row(1'b1, 32'h0));
    add_row(vertex_row(1'b1, 32'h0));
    add_row(known_row(1'b1, 32'h0, 2,
                      typed_facet(2, 0, 1, 1'b0), typed_facet(2, 1, 3, 1'b1)));
    // Next frame, extreme elevations: main diagonal differs by one, cross
    // diagonal spans the full signed range, so the main split wins.
    add_row(vertex_row(1'b1, 32'h7FFF_FFFF));
    add_row(vertex_row(1'b1, 32'h7FFF_FFFF));
    add_row(vertex_row(1'b1, 32'h8000_0000));
    add_row(known_row(1'b1, 32'h7FFF_FFFE, 2,
                      typed_facet(2, 0, 3, 1'b0), typed_facet(0, 1, 3, 1'b1)));
    // Swapped rows, lower-right corner missing: one triangle.
    add_row(write_row(ADDR_SWAP, 32'd1));
    add_row(vertex_row(1'b1, 32'h0000_0005));
    add_row(vertex_row(1'b0, 32'hFFFF_FFFF));
    add_row(vertex_row(1'b1, 32'h0001_0000));
    add_row(known_row(1'b1, 32'h8000_0001, 1, typed_facet(1, 0, 2, 1'b1), '0));
    // Out-of-range sizes saturate to 2; the spare address is ignored.
    add_row(write_row(ADDR_COLUMNS, 32'hFFFF_F801));
    add_row(write_row(ADDR_ROWS, 32'h0));
    add_row(write_row(ADDR_SPARE, 32'hA5A5_A5A5));
    // Two valid corners only: nothing.
    add_row(vertex_row(1'b0, 32'h1234_5678));
    add_row(vertex_row(1'b0, 32'h0));
    add_row(vertex_row(1'b1, 32'h0002_0000));
    add_row(known_row(1'b1, 32'hFFFE_0000, 0, '0, '0));
    add_row(write_row(ADDR_SWAP, 32'd0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        settle();
        apb_write(directed[i].addr, directed[i].data);
      end else begin
        send_vertex(directed[i].vv, directed[i].data, directed[i].known,
                    int'(directed[i].n_known), directed[i].t0, directed[i].t1);
      end
    end

    // Random phases. Each starts idle with new settings; two phases write a
    // width or a height at or above the maximum to exercise saturation.
    phase_no    = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 5))
        0: pct = 50;
        1: pct = 100;
        default: pct = 88;
      endcase
      if (phase_no == 2) begin
        apb_write(ADDR_COLUMNS, $urandom_range(1024, 2047));
        apb_write(ADDR_ROWS, $urandom_range(0, 2));
        items = $urandom_range(40, 80);
        run_vertices(items, 90);
      end else if (phase_no == 5) begin
        apb_write(ADDR_COLUMNS, 32'd2);
        apb_write(ADDR_ROWS, $urandom_range(1024, 2047));
        items = $urandom_range(60, 120);
        run_vertices(items, 90);
      end else begin
        // Most phases restart the frame; the rest only rewrite the orientation mid-frame.
        if ($urandom_range(0, 4) != 0) begin
          case ($urandom_range(0, 9))
            0: cols_word = $urandom_range(0, 1);
            1, 2: cols_word = $urandom_range(9, 40);
            default: cols_word = $urandom_range(2, 8);
          endcase
          if ($urandom_range(0, 3) == 0) cols_word = cols_word | ($urandom() & 32'hFFFF_F800);
          rows_word = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
          apb_write(ADDR_COLUMNS, cols_word);
          apb_write(ADDR_ROWS, rows_word);
        end
        apb_write(ADDR_SWAP, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) apb_write(ADDR_SPARE, $urandom());
        items = $urandom_range(30, 120);
        run_vertices(items, pct);
      end
      random_sent += items;
      phase_no++;
    end

    settle();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hgt_pkg.sv
sv/hgt_cell.sv
sv/height_grid_triangulator_top.sv
verif/height_grid_triangulator_top_tb.sv
